@@ hw/rtl/pfa_pkg.sv @@
// Shared constants, codes and types of the paged frame allocator.
`default_nettype none
package pfa_pkg;

  // Process slots addressed by the 4-bit pid field.
  localparam int MAX_PROCS = 16;
  localparam int PID_W = 4;
  // Deepest page table walk that the block supports.
  localparam int MAX_LEVELS = 4;
  localparam int DEF_NUM_FRAMES = 64;
  localparam int DEF_MAX_PAGES = 64;
  // Page number and table capacity accumulator; 31^4 stays below 2^20.
  localparam int ACC_W = 20;

  typedef enum logic [1:0] {
    CMD_CREATE    = 2'd0,
    CMD_TRANSLATE = 2'd1,
    CMD_DESTROY   = 2'd2,
    CMD_NONE      = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NO_SPACE = 3'd1,
    ST_CFG      = 3'd2,
    ST_NO_PROC  = 3'd3,
    ST_IN_USE   = 3'd4,
    ST_UNMAPPED = 3'd5
  } status_t;

  localparam logic [1:0] REG_PAGE_BYTES = 2'd0;
  localparam logic [1:0] REG_LEVEL_COUNT = 2'd1;
  localparam logic [1:0] REG_ENTRIES = 2'd2;

  // Per-cycle report of the frame table scan.
  typedef struct packed {
    logic alloc;
    logic release_frame;
    logic done;
  } scan_evt_t;

  // Process table update at the end of a create or destroy.
  typedef struct packed {
    logic             create;
    logic             destroy;
    logic [PID_W-1:0] pid;
  } proc_upd_t;

endpackage
`default_nettype wire

@@ hw/rtl/pfa_frame_scan.sv @@
// Frame ownership memory with its clearing pass and the create/destroy scan.
`default_nettype none
module pfa_frame_scan #(
  parameter int NUM_FRAMES = pfa_pkg::DEF_NUM_FRAMES,
  parameter int FW = 6,
  parameter int PCW = 7
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic                     is_create,
  input  wire logic [pfa_pkg::PID_W-1:0] pid,
  input  wire logic [PCW-1:0]           quota,
  output logic                          rdy,
  output pfa_pkg::scan_evt_t            evt,
  output logic [FW-1:0]                 evt_frame
);

  localparam int CW = $clog2(NUM_FRAMES + 1);
  localparam int EW = pfa_pkg::PID_W + 1;

  // Entry layout: owner pid above a used bit.
  logic [EW-1:0] mem [NUM_FRAMES];
  logic [EW-1:0] rd_q;

  logic          clearing_r;
  logic [FW-1:0] clr_idx_r;
  logic          busy_r;
  logic [CW-1:0] rd_idx_r;
  logic          chk_v_r;
  logic [FW-1:0] chk_idx_r;
  logic [PCW-1:0] alloc_r;
  logic          create_r;
  logic [pfa_pkg::PID_W-1:0] pid_r;
  logic [PCW-1:0] quota_r;

  logic          issue;
  logic          take;
  logic          rel;
  logic          last;
  logic          we;
  logic [FW-1:0] wa;
  logic [EW-1:0] wd;

  assign issue = busy_r && (32'(rd_idx_r) < NUM_FRAMES);
  assign take  = chk_v_r && create_r && !rd_q[0] && (alloc_r != quota_r);
  assign rel   = chk_v_r && !create_r && rd_q[0] && (rd_q[EW-1:1] == pid_r);
  assign last  = chk_v_r && (chk_idx_r == FW'(NUM_FRAMES - 1));

  always_comb begin
    we = 1'b0;
    wa = chk_idx_r;
    wd = '0;
    if (clearing_r) begin
      we = 1'b1;
      wa = clr_idx_r;
    end else if (take) begin
      we = 1'b1;
      wd = {pid_r, 1'b1};
    end else if (rel) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (issue) begin
      rd_q <= mem[rd_idx_r[FW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_idx_r  <= '0;
      busy_r     <= 1'b0;
      rd_idx_r   <= '0;
      chk_v_r    <= 1'b0;
      alloc_r    <= '0;
    end else begin
      if (clearing_r) begin
        clr_idx_r <= clr_idx_r + 1'b1;
        if (clr_idx_r == FW'(NUM_FRAMES - 1)) begin
          clearing_r <= 1'b0;
        end
      end
      chk_v_r <= issue;
      if (issue) begin
        chk_idx_r <= rd_idx_r[FW-1:0];
        rd_idx_r  <= rd_idx_r + 1'b1;
      end
      if (take) begin
        alloc_r <= alloc_r + 1'b1;
      end
      if (last) begin
        busy_r <= 1'b0;
      end
      if (start) begin
        busy_r   <= 1'b1;
        rd_idx_r <= '0;
        alloc_r  <= '0;
        create_r <= is_create;
        pid_r    <= pid;
        quota_r  <= quota;
      end
    end
  end

  assign rdy = !clearing_r && !busy_r;
  assign evt.alloc = take;
  assign evt.release_frame = rel;
  assign evt.done = last;
  assign evt_frame = chk_idx_r;

`ifndef SYNTHESIS
  a_alloc_quota: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (32'(alloc_r) <= 32'(quota_r)))
    else $error("allocation count passed the page quota");
`endif

endmodule
`default_nettype wire

@@ hw/rtl/pfa_page_map.sv @@
// Page map memory with per-process live flags and page counts.
`default_nettype none
module pfa_page_map #(
  parameter int MAX_PAGES = pfa_pkg::DEF_MAX_PAGES,
  parameter int FW = 6,
  parameter int PGW = 6,
  parameter int PCW = 7
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      wr_en,
  input  wire logic [pfa_pkg::PID_W-1:0] wr_pid,
  input  wire logic [PGW-1:0]            wr_page,
  input  wire logic [FW-1:0]             wr_frame,
  input  wire logic                      rd_en,
  input  wire logic [pfa_pkg::PID_W-1:0] rd_pid,
  input  wire logic [PGW-1:0]            rd_page,
  output logic [FW-1:0]                  rd_frame,
  output logic                           rd_hit,
  input  wire pfa_pkg::proc_upd_t        upd,
  input  wire logic [PCW-1:0]            upd_pages,
  input  wire logic [pfa_pkg::PID_W-1:0] live_pid,
  output logic                           live
);

  localparam int AW = pfa_pkg::PID_W + PGW;

  // Entries of a page at or beyond the process page count read as unmapped,
  // so the memory needs no clearing.
  logic [FW-1:0]  mem [2**AW];
  logic [pfa_pkg::MAX_PROCS-1:0] live_r;
  logic [PCW-1:0] cnt_r [pfa_pkg::MAX_PROCS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[{wr_pid, wr_page}] <= wr_frame;
    end
    if (rd_en) begin
      rd_frame <= mem[{rd_pid, rd_page}];
      rd_hit   <= (32'(rd_page) < 32'(cnt_r[rd_pid])) && (32'(rd_page) < MAX_PAGES);
    end
  end

  always_ff @(posedge clk) begin
    if (upd.create) begin
      cnt_r[upd.pid] <= upd_pages;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r <= '0;
    end else if (upd.create) begin
      live_r[upd.pid] <= 1'b1;
    end else if (upd.destroy) begin
      live_r[upd.pid] <= 1'b0;
    end
  end

  assign live = live_r[live_pid];

endmodule
`default_nettype wire

@@ hw/rtl/paged_frame_allocator.sv @@
// Top level of the paged frame allocator: command sequencer and result register.
//
// Requests arrive on the in_ stream, one command per request: create a process
// with a size in bytes, translate a page of a process through up to four table
// indices, or destroy a process. Each request yields exactly one result on
// the out_ stream with a status, the translated frame and the free frame count.
// Configuration (page size, levels, entries per level) is written through the
// cfg_ port; the user must do so while no request is in flight, as the block
// does not enforce it. Create counts its pages, checks the table geometry and
// then scans the frame ownership memory, one frame per cycle; destroy runs the
// same scan. Translate walks one table level per cycle, then reads the page
// map. Commands that fail at decode go straight to their result.
// One request is in flight at a time.
// After reset the frame memory is cleared, one entry per cycle, and in_tready
// stays low until that pass ends. All processes are dead and all frames free.
// A result is held in the output register while out_tready is low; the next
// request is accepted meanwhile and its result waits until the register frees.
`default_nettype none
module paged_frame_allocator #(
  parameter int NUM_FRAMES = pfa_pkg::DEF_NUM_FRAMES,
  parameter int MAX_PAGES = pfa_pkg::DEF_MAX_PAGES
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // cmd, pid, size_bytes, index_level_one .. index_level_four, zero fill
  input  wire logic [47:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // status, frame_number, free_frames
  output logic [15:0]      out_tdata,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [16:0] cfg_wdata
);

  localparam int FW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int FCW = $clog2(NUM_FRAMES + 1);
  localparam int PGW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int PCW = $clog2(MAX_PAGES + 1);
  localparam int AW = pfa_pkg::ACC_W;

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_DIV, S_GEO, S_XL, S_RD, S_SCAN, S_DONE
  } state_t;

  state_t state_r;

  // Configuration registers.
  logic [16:0] pb_r;
  logic [2:0]  lvl_cfg_r;
  logic [4:0]  ent_r;

  // Latched request.
  logic [1:0]  cmd_r;
  logic [pfa_pkg::PID_W-1:0] pid_r;
  logic [20:0] rem_r;
  logic [3:0]  idx_r [4];

  logic [PCW-1:0] cnt_r;
  logic [2:0]     lvl_r;
  logic [AW-1:0]  acc_r;
  logic [PGW-1:0] pg_r;
  logic [FCW-1:0] rel_r;
  logic [FCW-1:0] free_r;
  logic           start_r;
  logic [2:0]     res_status_r;
  logic [FW-1:0]  res_frame_r;

  logic        out_valid_r;
  logic [2:0]  out_status_r;
  logic [5:0]  out_frame_r;
  logic [6:0]  out_free_r;

  logic        scan_rdy;
  pfa_pkg::scan_evt_t evt;
  logic [FW-1:0] evt_frame;
  logic [FW-1:0] pm_frame;
  logic        pm_hit;
  logic        live;
  pfa_pkg::proc_upd_t upd;
  logic        pm_rd_en;

  logic [16:0] pb_eff;
  logic        levels_ok;
  logic [3:0]  cur_idx;
  logic [FCW-1:0] rel_sum;

  assign pb_eff = (pb_r == '0) ? 17'd1 : pb_r;
  assign levels_ok = (lvl_cfg_r >= 3'd1) && (lvl_cfg_r <= 3'd4) &&
                     (32'(lvl_cfg_r) <= pfa_pkg::MAX_LEVELS);
  assign cur_idx = idx_r[lvl_r[1:0]];
  assign rel_sum = rel_r + FCW'(evt.release_frame);
  assign pm_rd_en = (state_r == S_XL) && (lvl_r == lvl_cfg_r) &&
                    (32'(acc_r) < MAX_PAGES);

  assign upd.create  = (state_r == S_SCAN) && evt.done && (cmd_r == pfa_pkg::CMD_CREATE);
  assign upd.destroy = (state_r == S_SCAN) && evt.done && (cmd_r == pfa_pkg::CMD_DESTROY);
  assign upd.pid     = pid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pb_r      <= 17'd64;
      lvl_cfg_r <= 3'd3;
      ent_r     <= 5'd4;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        pfa_pkg::REG_PAGE_BYTES:  pb_r <= cfg_wdata;
        pfa_pkg::REG_LEVEL_COUNT: lvl_cfg_r <= cfg_wdata[2:0];
        pfa_pkg::REG_ENTRIES:     ent_r <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      free_r      <= FCW'(NUM_FRAMES);
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // The result register reloads in S_DONE, which handles its own handshake.
      if (out_valid_r && out_tready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid && in_tready) begin
            cmd_r    <= in_tdata[1:0];
            pid_r    <= in_tdata[5:2];
            rem_r    <= in_tdata[26:6];
            idx_r[0] <= in_tdata[30:27];
            idx_r[1] <= in_tdata[34:31];
            idx_r[2] <= in_tdata[38:35];
            idx_r[3] <= in_tdata[42:39];
            state_r  <= S_DECODE;
          end
        end
        S_DECODE: begin
          res_frame_r <= '0;
          cnt_r <= '0;
          lvl_r <= '0;
          acc_r <= '0;
          pg_r  <= '0;
          rel_r <= '0;
          if (cmd_r == pfa_pkg::CMD_NONE) begin
            res_status_r <= pfa_pkg::ST_OK;
            state_r <= S_DONE;
          end else if (32'(pid_r) >= pfa_pkg::MAX_PROCS) begin
            res_status_r <= pfa_pkg::ST_NO_PROC;
            state_r <= S_DONE;
          end else if (cmd_r == pfa_pkg::CMD_CREATE) begin
            if (live) begin
              res_status_r <= pfa_pkg::ST_IN_USE;
              state_r <= S_DONE;
            end else begin
              state_r <= S_DIV;
            end
          end else if (!live) begin
            res_status_r <= pfa_pkg::ST_NO_PROC;
            state_r <= S_DONE;
          end else if (cmd_r == pfa_pkg::CMD_DESTROY) begin
            start_r <= 1'b1;
            state_r <= S_SCAN;
          end else if (!levels_ok) begin
            res_status_r <= pfa_pkg::ST_UNMAPPED;
            state_r <= S_DONE;
          end else begin
            state_r <= S_XL;
          end
        end
        S_DIV: begin
          // Page count by repeated subtraction, capped at MAX_PAGES.
          if (rem_r == '0) begin
            if (32'(cnt_r) > 32'(free_r)) begin
              res_status_r <= pfa_pkg::ST_NO_SPACE;
              state_r <= S_DONE;
            end else if (!levels_ok) begin
              res_status_r <= pfa_pkg::ST_CFG;
              state_r <= S_DONE;
            end else begin
              acc_r <= AW'(1);
              state_r <= S_GEO;
            end
          end else if (32'(cnt_r) == MAX_PAGES) begin
            res_status_r <= pfa_pkg::ST_NO_SPACE;
            state_r <= S_DONE;
          end else begin
            rem_r <= (rem_r > 21'(pb_eff)) ? (rem_r - 21'(pb_eff)) : '0;
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_GEO: begin
          // Table capacity entries^levels, one level per cycle.
          if (lvl_r == lvl_cfg_r) begin
            if (32'(acc_r) >= NUM_FRAMES) begin
              start_r <= 1'b1;
              state_r <= S_SCAN;
            end else begin
              res_status_r <= pfa_pkg::ST_CFG;
              state_r <= S_DONE;
            end
          end else begin
            acc_r <= AW'(acc_r * ent_r);
            lvl_r <= lvl_r + 1'b1;
          end
        end
        S_XL: begin
          if (lvl_r == lvl_cfg_r) begin
            if (pm_rd_en) begin
              state_r <= S_RD;
            end else begin
              res_status_r <= pfa_pkg::ST_UNMAPPED;
              state_r <= S_DONE;
            end
          end else if ({1'b0, cur_idx} >= ent_r) begin
            res_status_r <= pfa_pkg::ST_UNMAPPED;
            state_r <= S_DONE;
          end else begin
            acc_r <= AW'(acc_r * ent_r + AW'(cur_idx));
            lvl_r <= lvl_r + 1'b1;
          end
        end
        S_RD: begin
          if (pm_hit) begin
            res_status_r <= pfa_pkg::ST_OK;
            res_frame_r  <= pm_frame;
          end else begin
            res_status_r <= pfa_pkg::ST_UNMAPPED;
          end
          state_r <= S_DONE;
        end
        S_SCAN: begin
          // The start pulse lasts the first cycle of the scan only.
          start_r <= 1'b0;
          if (evt.alloc) begin
            pg_r <= pg_r + 1'b1;
          end
          if (evt.release_frame) begin
            rel_r <= rel_sum;
          end
          if (evt.done) begin
            if (cmd_r == pfa_pkg::CMD_CREATE) begin
              free_r <= free_r - FCW'(cnt_r);
            end else begin
              free_r <= free_r + rel_sum;
            end
            res_status_r <= pfa_pkg::ST_OK;
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_frame_r  <= 6'(res_frame_r);
            out_free_r   <= 7'(free_r);
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE) && scan_rdy;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_free_r, out_frame_r, out_status_r};

  pfa_frame_scan #(
    .NUM_FRAMES(NUM_FRAMES),
    .FW(FW),
    .PCW(PCW)
  ) u_scan (
    .clk(clk),
    .rst_n(rst_n),
    .start(start_r),
    .is_create(cmd_r == pfa_pkg::CMD_CREATE),
    .pid(pid_r),
    .quota(cnt_r),
    .rdy(scan_rdy),
    .evt(evt),
    .evt_frame(evt_frame)
  );

  pfa_page_map #(
    .MAX_PAGES(MAX_PAGES),
    .FW(FW),
    .PGW(PGW),
    .PCW(PCW)
  ) u_pmap (
    .clk(clk),
    .rst_n(rst_n),
    .wr_en((state_r == S_SCAN) && evt.alloc),
    .wr_pid(pid_r),
    .wr_page(pg_r),
    .wr_frame(evt_frame),
    .rd_en(pm_rd_en),
    .rd_pid(pid_r),
    .rd_page(acc_r[PGW-1:0]),
    .rd_frame(pm_frame),
    .rd_hit(pm_hit),
    .upd(upd),
    .upd_pages(cnt_r),
    .live_pid(pid_r),
    .live(live)
  );

`ifndef SYNTHESIS
  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(free_r) <= NUM_FRAMES)
    else $error("free frame count above the number of frames");
  a_evt_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(evt.alloc && evt.release_frame))
    else $error("scan allocated and released in one cycle");
  a_done_leaves: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && evt.done) |=> (state_r == S_DONE))
    else $error("sequencer missed the end of the frame scan");
`endif

endmodule
`default_nettype wire

@@ test/pfa_checker.sv @@
// Checker for the paged frame allocator: watches both streams, predicts each result and compares.
`timescale 1ns / 100ps
`default_nettype none
module pfa_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [47:0] in_tdata,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [15:0] out_tdata,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [16:0] cfg_wdata,
  output int               fail_count,
  output int               pending_count
);

  localparam int FRAMES = 64;
  localparam int PAGES = 64;

  // Same order as out_tdata from the top bit down: free, frame, status.
  typedef struct packed {
    logic [6:0]       free;
    logic [5:0]       frame;
    pfa_pkg::status_t status;
  } outcome_t;

  logic             used_q [FRAMES];
  logic [3:0]       owner_q [FRAMES];
  logic             map_valid [pfa_pkg::MAX_PROCS][PAGES];
  logic [5:0]       map_frame [pfa_pkg::MAX_PROCS][PAGES];
  logic             live_q [pfa_pkg::MAX_PROCS];
  int               free_q;
  logic [16:0]      page_bytes_q;
  logic [2:0]       levels_q;
  logic [4:0]       entries_q;
  outcome_t         outcome_q [$];

  function automatic bit levels_fine();
    return levels_q >= 1 && levels_q <= pfa_pkg::MAX_LEVELS;
  endfunction

  // One command applied to the shadow state; returns the result it should give.
  function automatic outcome_t allocate_step(logic [47:0] req);
    pfa_pkg::cmd_t cmd;
    logic [3:0] pid;
    int         size, pb, pages, cap, pg, idx;
    outcome_t   r;
    cmd = pfa_pkg::cmd_t'(req[1:0]);
    pid = req[5:2];
    size = req[26:6];
    r.status = pfa_pkg::ST_OK;
    r.frame = '0;
    case (cmd)
      pfa_pkg::CMD_CREATE: begin
        pb = (page_bytes_q == 0) ? 1 : page_bytes_q;
        pages = (size + pb - 1) / pb;
        cap = 1;
        for (int l = 0; l < levels_q; l++) cap *= entries_q;
        if (live_q[pid]) r.status = pfa_pkg::ST_IN_USE;
        else if (pages > free_q || pages > PAGES) r.status = pfa_pkg::ST_NO_SPACE;
        else if (!levels_fine() || cap < FRAMES) r.status = pfa_pkg::ST_CFG;
        else begin
          for (int p = 0; p < PAGES; p++) map_valid[pid][p] = 1'b0;
          for (int p = 0; p < pages; p++) begin
            for (int f = 0; f < FRAMES; f++) begin
              if (!used_q[f]) begin
                used_q[f] = 1'b1;
                owner_q[f] = pid;
                map_valid[pid][p] = 1'b1;
                map_frame[pid][p] = 6'(f);
                free_q--;
                break;
              end
            end
          end
          live_q[pid] = 1'b1;
        end
      end
      pfa_pkg::CMD_TRANSLATE: begin
        if (!live_q[pid]) r.status = pfa_pkg::ST_NO_PROC;
        else if (!levels_fine()) r.status = pfa_pkg::ST_UNMAPPED;
        else begin
          pg = 0;
          for (int l = 0; l < levels_q; l++) begin
            idx = req[27 + 4*l +: 4];
            if (idx >= entries_q) r.status = pfa_pkg::ST_UNMAPPED;
            pg = pg * entries_q + idx;
          end
          if (r.status == pfa_pkg::ST_OK) begin
            if (pg >= PAGES || !map_valid[pid][pg]) r.status = pfa_pkg::ST_UNMAPPED;
            else r.frame = map_frame[pid][pg];
          end
        end
      end
      pfa_pkg::CMD_DESTROY: begin
        if (!live_q[pid]) r.status = pfa_pkg::ST_NO_PROC;
        else begin
          for (int f = 0; f < FRAMES; f++) begin
            if (used_q[f] && owner_q[f] == pid) begin
              used_q[f] = 1'b0;
              owner_q[f] = '0;
              free_q++;
            end
          end
          for (int p = 0; p < PAGES; p++) map_valid[pid][p] = 1'b0;
          live_q[pid] = 1'b0;
        end
      end
      default: ;
    endcase
    r.free = 7'(free_q);
    return r;
  endfunction

  assign pending_count = outcome_q.size();

  always @(posedge clk) begin
    outcome_t got, want;
    if (!rst_n) begin
      for (int f = 0; f < FRAMES; f++) begin
        used_q[f] <= 1'b0;
        owner_q[f] <= '0;
      end
      for (int p = 0; p < pfa_pkg::MAX_PROCS; p++) begin
        live_q[p] <= 1'b0;
        for (int g = 0; g < PAGES; g++) map_valid[p][g] <= 1'b0;
      end
      free_q <= FRAMES;
      page_bytes_q <= 17'd64;
      levels_q <= 3'd3;
      entries_q <= 5'd4;
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          pfa_pkg::REG_PAGE_BYTES:  page_bytes_q = cfg_wdata;
          pfa_pkg::REG_LEVEL_COUNT: levels_q = cfg_wdata[2:0];
          pfa_pkg::REG_ENTRIES:     entries_q = cfg_wdata[4:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) outcome_q.push_back(allocate_step(in_tdata));
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (outcome_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result %h", out_tdata);
        end else begin
          want = outcome_q.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: status %0d/%0d frame %0d/%0d free %0d/%0d (exp/act)",
                       want.status, got.status, want.frame, got.frame, want.free, got.free);
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

@@ test/tb.sv @@
// Testbench top of the paged frame allocator: stimulus, configuration phases and verdict.
`timescale 1ns / 100ps
`default_nettype none
module tb;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = pfa_pkg::REG_PAGE_BYTES;
  logic [16:0] cfg_wdata = '0;
  int          fail_count;
  int          pending_count;
  // Percent of cycles in which the sender idles or the receiver stalls.
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          quiet_cycles = 0;

  localparam int WATCHDOG_LIMIT = 20000;

  always #4 clk = ~clk;

  paged_frame_allocator dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .out_tvalid, .out_tready,
    .out_tdata, .cfg_we, .cfg_addr, .cfg_wdata
  );

  pfa_checker checker_i (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .out_tvalid, .out_tready,
    .out_tdata, .cfg_we, .cfg_addr, .cfg_wdata, .fail_count, .pending_count
  );

  // The receiver stalls at random, changing its ready at the falling edge.
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog: counts cycles in which neither stream moves a request or result.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Sends one request and holds it until the block takes it. The random gap
  // comes first, so valid stays high between back-to-back requests.
  task automatic send_request(pfa_pkg::cmd_t cmd, logic [3:0] pid, logic [20:0] size,
                              logic [15:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {5'd0, idx, size, pid, cmd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Lowers valid and waits until every expected result is back, plus a
  // margin for commands still finishing inside the block.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending_count != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] addr, logic [16:0] value);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_geometry(logic [16:0] pb, logic [2:0] lv, logic [4:0] ent);
    drain();
    write_reg(pfa_pkg::REG_PAGE_BYTES, pb);
    write_reg(pfa_pkg::REG_LEVEL_COUNT, {14'd0, lv});
    write_reg(pfa_pkg::REG_ENTRIES, {12'd0, ent});
  endtask

  // Random requests: mostly translates into pages that are likely mapped,
  // then creates of small sizes and destroys, with a share of plain noise.
  task automatic random_requests(int count, int ent);
    int          kind;
    logic [15:0] idx;
    logic [20:0] size;
    for (int n = 0; n < count; n++) begin
      kind = $urandom_range(99);
      idx = 16'($urandom);
      if (ent > 0 && kind < 70)
        for (int l = 0; l < 4; l++) idx[4*l +: 4] = 4'($urandom_range(ent - 1));
      if (kind < 85) size = 21'($urandom_range(1000));
      else size = 21'($urandom);
      if (kind < 30) send_request(pfa_pkg::CMD_CREATE, 4'($urandom), size, idx);
      else if (kind < 80) send_request(pfa_pkg::CMD_TRANSLATE, 4'($urandom), size, idx);
      else if (kind < 96) send_request(pfa_pkg::CMD_DESTROY, 4'($urandom), size, idx);
      else send_request(pfa_pkg::CMD_NONE, 4'($urandom), size, idx);
    end
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part under the reset geometry: 64-byte pages, 3 levels of 4.
    send_request(pfa_pkg::CMD_CREATE, 4'd0, 21'd0, 16'h0);           // zero size maps nothing
    send_request(pfa_pkg::CMD_CREATE, 4'd0, 21'd64, 16'h0);          // pid already live
    send_request(pfa_pkg::CMD_TRANSLATE, 4'd0, 21'd0, 16'h0);        // live but unmapped
    send_request(pfa_pkg::CMD_CREATE, 4'd1, 21'd130, 16'h0);         // three pages
    send_request(pfa_pkg::CMD_TRANSLATE, 4'd1, 21'd0, 16'h0200);     // page 2
    send_request(pfa_pkg::CMD_TRANSLATE, 4'd1, 21'd0, 16'h0004);     // index beyond entries
    send_request(pfa_pkg::CMD_TRANSLATE, 4'd9, 21'd0, 16'h0);        // dead pid
    send_request(pfa_pkg::CMD_CREATE, 4'd15, 21'h1FFFFF, 16'hFFFF);  // too large
    send_request(pfa_pkg::CMD_CREATE, 4'd14, 21'd3904, 16'h0);       // 61 pages, fills memory
    send_request(pfa_pkg::CMD_TRANSLATE, 4'd14, 21'd0, 16'h0333);    // page 63, beyond the page count
    send_request(pfa_pkg::CMD_CREATE, 4'd2, 21'd1, 16'h0);           // no frame left
    send_request(pfa_pkg::CMD_NONE, 4'd15, 21'h1FFFFF, 16'hFFFF);    // unused command
    send_request(pfa_pkg::CMD_DESTROY, 4'd14, 21'd0, 16'h0);
    send_request(pfa_pkg::CMD_DESTROY, 4'd14, 21'd0, 16'h0);         // already gone
    send_request(pfa_pkg::CMD_CREATE, 4'd2, 21'd4096, 16'h0);        // exactly 64 pages
    send_request(pfa_pkg::CMD_DESTROY, 4'd2, 21'd0, 16'h0);
    send_request(pfa_pkg::CMD_DESTROY, 4'd1, 21'd0, 16'h0);
    send_request(pfa_pkg::CMD_DESTROY, 4'd0, 21'd0, 16'h0);

    // Table too small for the frame count, then a bad level count.
    set_geometry(17'd1, 3'd2, 5'd4);
    send_request(pfa_pkg::CMD_CREATE, 4'd3, 21'd5, 16'h0);
    set_geometry(17'd0, 3'd0, 5'd16);
    send_request(pfa_pkg::CMD_CREATE, 4'd3, 21'd5, 16'h0);
    send_request(pfa_pkg::CMD_TRANSLATE, 4'd3, 21'd0, 16'h0);
    set_geometry(17'd0, 3'd7, 5'd31);
    send_request(pfa_pkg::CMD_CREATE, 4'd3, 21'd5, 16'h0);

    // Random phases with each idling pattern and several geometries.
    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
        default: begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      case (phase)
        0: begin set_geometry(17'd64, 3'd3, 5'd4);     random_requests(230, 4);  end
        1: begin set_geometry(17'd16, 3'd1, 5'd16);    random_requests(230, 16); end
        2: begin set_geometry(17'd65535, 3'd4, 5'd3);  random_requests(230, 3);  end
        3: begin set_geometry(17'h10000, 3'd2, 5'd8);  random_requests(230, 8);  end
        4: begin set_geometry(17'd1, 3'd6, 5'd0);      random_requests(230, 2);  end
        5: begin set_geometry(17'd100, 3'd2, 5'd16);   random_requests(230, 8);  end
        6: begin set_geometry(17'h1FFFF, 3'd1, 5'd31); random_requests(230, 16); end
        default: begin set_geometry(17'd32, 3'd3, 5'd4); random_requests(230, 4); end
      endcase
    end

    drain();
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
`default_nettype wire

@@ files.f @@
hw/rtl/pfa_pkg.sv
hw/rtl/pfa_frame_scan.sv
hw/rtl/pfa_page_map.sv
hw/rtl/paged_frame_allocator.sv
test/pfa_checker.sv
test/tb.sv
